// File: src/rtf_token_scanner_top_defines.svh
// assertion macros for the rtf token scanner
// used by rtf_token_scanner_top; relies on aclk and aresetn in scope
`ifndef RTF_TOKEN_SCANNER_TOP_DEFINES_SVH
`define RTF_TOKEN_SCANNER_TOP_DEFINES_SVH

// implication checked at every clock edge while out of reset
`define RTS_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// implication checked on the cycle after the condition
`define RTS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: src/rtfts_pkg.sv
// shared types and constants of the rtf token scanner
// used by rtfts_core and rtf_token_scanner_top; no dependencies
package rtfts_pkg;

    // event codes carried on the result channel
    localparam logic [3:0] EV_OPEN  = 4'd0;
    localparam logic [3:0] EV_CLOSE = 4'd1;
    localparam logic [3:0] EV_SYM   = 4'd2;
    localparam logic [3:0] EV_WCHAR = 4'd3;
    localparam logic [3:0] EV_PCHAR = 4'd4;
    localparam logic [3:0] EV_WEND  = 4'd5;
    localparam logic [3:0] EV_TCHAR = 4'd6;
    localparam logic [3:0] EV_TEND  = 4'd7;
    localparam logic [3:0] EV_EOF   = 4'd8;

    // special characters
    localparam logic [7:0] CH_NONE   = 8'd0;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    // decode of one word: up to two events in order
    typedef struct packed {
        logic [1:0] count;
        logic [3:0] ev0;
        logic [7:0] ch0;
        logic [3:0] ev1;
        logic [7:0] ch1;
    } decode_t;

endpackage

// File: src/rtfts_core.sv
// scanner mode register and per-word event decode
// depends on rtfts_pkg
module rtfts_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        in_byte,
    input  logic              end_of_input,
    input  logic              advance,
    output rtfts_pkg::decode_t dec
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BSL,
        MODE_NAME,
        MODE_PARAM,
        MODE_TEXT
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;

    // prefix event (decoded from the current mode) and the idle rescan of the byte
    logic       pre_valid;
    logic [3:0] pre_ev;
    logic [7:0] pre_ch;
    logic       rescan;
    logic       idl_valid;
    logic [3:0] idl_ev;
    logic [7:0] idl_ch;
    mode_t      idl_mode;

    logic is_ws;
    logic is_letter;
    logic is_digit;

    // character classes, ascii only
    always_comb begin
        is_ws     = (in_byte == rtfts_pkg::CH_SPACE) || (in_byte >= 8'd9 && in_byte <= 8'd13);
        is_letter = (in_byte >= 8'd65 && in_byte <= 8'd90) ||
                    (in_byte >= 8'd97 && in_byte <= 8'd122);
        is_digit  = (in_byte >= 8'd48 && in_byte <= 8'd57);
    end

    // scan of the byte from idle
    always_comb begin
        idl_valid = 1'b1;
        idl_ev    = rtfts_pkg::EV_TCHAR;
        idl_ch    = in_byte;
        idl_mode  = MODE_TEXT;
        priority if (is_ws) begin
            idl_valid = 1'b0;
            idl_mode  = MODE_IDLE;
        end else if (in_byte == rtfts_pkg::CH_BSLASH) begin
            idl_valid = 1'b0;
            idl_mode  = MODE_BSL;
        end else if (in_byte == rtfts_pkg::CH_LBRACE) begin
            idl_ev   = rtfts_pkg::EV_OPEN;
            idl_ch   = rtfts_pkg::CH_NONE;
            idl_mode = MODE_IDLE;
        end else if (in_byte == rtfts_pkg::CH_RBRACE) begin
            idl_ev   = rtfts_pkg::EV_CLOSE;
            idl_ch   = rtfts_pkg::CH_NONE;
            idl_mode = MODE_IDLE;
        end else begin
            idl_mode = MODE_TEXT;
        end
    end

    // main decode by mode
    always_comb begin
        pre_valid = 1'b0;
        pre_ev    = rtfts_pkg::EV_EOF;
        pre_ch    = rtfts_pkg::CH_NONE;
        rescan    = 1'b0;
        mode_next = mode_reg;
        if (end_of_input) begin
            // close pending token, then end of file
            mode_next = MODE_IDLE;
            unique case (mode_reg)
                MODE_TEXT: begin
                    pre_valid = 1'b1;
                    pre_ev    = rtfts_pkg::EV_TEND;
                end
                MODE_NAME, MODE_PARAM: begin
                    pre_valid = 1'b1;
                    pre_ev    = rtfts_pkg::EV_WEND;
                end
                default: pre_valid = 1'b0;
            endcase
        end else begin
            unique case (mode_reg)
                MODE_BSL: begin
                    pre_valid = 1'b1;
                    pre_ch    = in_byte;
                    priority if (is_letter) begin
                        mode_next = MODE_NAME;
                        pre_ev    = rtfts_pkg::EV_WCHAR;
                    end else if (is_digit) begin
                        mode_next = MODE_PARAM;
                        pre_ev    = rtfts_pkg::EV_PCHAR;
                    end else begin
                        mode_next = MODE_IDLE;
                        pre_ev    = rtfts_pkg::EV_SYM;
                    end
                end
                MODE_NAME: begin
                    pre_valid = 1'b1;
                    priority if (is_letter) begin
                        pre_ev = rtfts_pkg::EV_WCHAR;
                        pre_ch = in_byte;
                    end else if (in_byte == rtfts_pkg::CH_SPACE) begin
                        mode_next = MODE_IDLE;
                        pre_ev    = rtfts_pkg::EV_WEND;
                        pre_ch    = rtfts_pkg::CH_SPACE;
                    end else if (is_digit || in_byte == rtfts_pkg::CH_MINUS) begin
                        mode_next = MODE_PARAM;
                        pre_ev    = rtfts_pkg::EV_PCHAR;
                        pre_ch    = in_byte;
                    end else begin
                        pre_ev = rtfts_pkg::EV_WEND;
                        rescan = 1'b1;
                    end
                end
                MODE_PARAM: begin
                    pre_valid = 1'b1;
                    priority if (is_letter || is_digit) begin
                        pre_ev = rtfts_pkg::EV_PCHAR;
                        pre_ch = in_byte;
                    end else if (in_byte == rtfts_pkg::CH_SPACE) begin
                        mode_next = MODE_IDLE;
                        pre_ev    = rtfts_pkg::EV_WEND;
                        pre_ch    = rtfts_pkg::CH_SPACE;
                    end else begin
                        pre_ev = rtfts_pkg::EV_WEND;
                        rescan = 1'b1;
                    end
                end
                MODE_TEXT: begin
                    pre_valid = 1'b1;
                    if (in_byte == rtfts_pkg::CH_BSLASH || in_byte == rtfts_pkg::CH_LBRACE ||
                        in_byte == rtfts_pkg::CH_RBRACE) begin
                        pre_ev = rtfts_pkg::EV_TEND;
                        rescan = 1'b1;
                    end else begin
                        pre_ev = rtfts_pkg::EV_TCHAR;
                        pre_ch = in_byte;
                    end
                end
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                mode_next = idl_mode;
            end
        end
    end

    // order the events: prefix first, then eof or rescan result
    always_comb begin
        dec.ev1 = rtfts_pkg::EV_EOF;
        dec.ch1 = rtfts_pkg::CH_NONE;
        if (end_of_input) begin
            if (pre_valid) begin
                dec.count = 2'd2;
                dec.ev0   = pre_ev;
                dec.ch0   = pre_ch;
            end else begin
                dec.count = 2'd1;
                dec.ev0   = rtfts_pkg::EV_EOF;
                dec.ch0   = rtfts_pkg::CH_NONE;
            end
        end else if (pre_valid) begin
            dec.ev0   = pre_ev;
            dec.ch0   = pre_ch;
            dec.ev1   = idl_ev;
            dec.ch1   = idl_ch;
            dec.count = (rescan && idl_valid) ? 2'd2 : 2'd1;
        end else begin
            dec.ev0   = idl_ev;
            dec.ch0   = idl_ch;
            dec.count = (rescan && idl_valid) ? 2'd1 : 2'd0;
        end
    end

    // scanner mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// File: src/rtf_token_scanner_top.sv
// rtf token scanner: one input byte per cycle while the result channel takes events and no second
// event is held; up to two events per byte. Path: input register, then result register
// a byte with two events holds the input while its second event drains from the hold register
// reset: synchronous aresetn clears all valid flags and returns the scanner to idle
`include "rtf_token_scanner_top_defines.svh"

module rtf_token_scanner_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [3:0] m_tuser,   // [3:0] event_res
    output logic       m_tlast
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    // result register and second-event hold register
    logic       out_valid_reg;
    logic [3:0] out_event_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       pend_valid_reg;
    logic [3:0] pend_event_reg;
    logic [7:0] pend_char_reg;

    rtfts_pkg::decode_t dec;
    logic               out_free;
    logic               consume;

    rtfts_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_byte      (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .advance      (consume),
        .dec          (dec)
    );

    // a word leaves the input register when its events fit
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && !pend_valid_reg && ((dec.count == 2'd0) || out_free);
    assign s_tready = !in_valid_reg || consume;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
    end

    // result register, fed from the hold register first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (pend_valid_reg && out_free) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (consume && dec.count != 2'd0) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= (dec.count == 2'd2);
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (pend_valid_reg && out_free) begin
            out_event_reg <= pend_event_reg;
            out_char_reg  <= pend_char_reg;
            out_last_reg  <= 1'b1;
        end else if (consume && dec.count != 2'd0) begin
            out_event_reg <= dec.ev0;
            out_char_reg  <= dec.ch0;
            out_last_reg  <= (dec.count == 2'd1);
        end
        if (consume && dec.count == 2'd2) begin
            pend_event_reg <= dec.ev1;
            pend_char_reg  <= dec.ch1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_event_reg;
    assign m_tlast  = out_last_reg;

    // checks
    `RTS_ASSERT_IMPL(a_pend_behind_out, pend_valid_reg, out_valid_reg, "held event without result")
    `RTS_ASSERT_IMPL(a_no_consume_pend, pend_valid_reg, !consume, "word taken while event held")
    `RTS_ASSERT_NEXT(a_two_events_hold, consume && dec.count == 2'd2, pend_valid_reg,
                     "second event not held")
    `RTS_ASSERT_IMPL(a_eof_is_last, out_valid_reg && out_event_reg == rtfts_pkg::EV_EOF,
                     out_last_reg, "end of file not marked last")

endmodule

// File: tb/sv/rtf_token_scanner_top_tb.sv
// self-checking testbench for rtf_token_scanner_top: directed table, then random rtf-like streams
// depends on rtfts_pkg and the rtf_token_scanner_top rtl; reads and writes no files
module rtf_token_scanner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // scanner modes tracked by the predictor
    typedef enum logic [2:0] {
        SM_IDLE,
        SM_BSL,
        SM_NAME,
        SM_PARAM,
        SM_TEXT
    } scan_mode_t;

    // one token event as seen on the result channel
    typedef struct packed {
        logic [3:0] ev;
        logic [7:0] ch;
        logic       is_last;
    } token_ev_t;

    // one input word
    typedef struct packed {
        logic       eoi;
        logic [7:0] data;
    } byte_word_t;

    // directed row: input word, then typed events where typed is set
    typedef struct packed {
        logic       eoi;
        logic [7:0] data;
        logic       typed;
        logic [1:0] cnt;
        logic [3:0] e0;
        logic [7:0] c0;
        logic [3:0] e1;
        logic [7:0] c1;
    } dir_row_t;

    localparam int DIR_ROWS_N = 25;
    localparam int RAND_PER_PHASE = 617;

    // directed stimulus; rows with typed=0 go through the predictor
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // group open and close from idle
        '{1'b0, rtfts_pkg::CH_LBRACE, 1'b1, 2'd1,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, rtfts_pkg::CH_RBRACE, 1'b1, 2'd1,
          rtfts_pkg::EV_CLOSE, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        // text with the byte extremes
        '{1'b0, 8'h00, 1'b1, 2'd1,
          rtfts_pkg::EV_TCHAR, 8'h00, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'hFF, 1'b1, 2'd1,
          rtfts_pkg::EV_TCHAR, 8'hFF, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        // backslash ends the text, then backslash-space is a symbol
        '{1'b0, rtfts_pkg::CH_BSLASH, 1'b1, 2'd1,
          rtfts_pkg::EV_TEND, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, rtfts_pkg::CH_SPACE, 1'b1, 2'd1,
          rtfts_pkg::EV_SYM, rtfts_pkg::CH_SPACE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        // control word with minus-led parameter that runs over a letter
        '{1'b0, rtfts_pkg::CH_BSLASH, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h61, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h5A, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, rtfts_pkg::CH_MINUS, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h37, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h71, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, rtfts_pkg::CH_SPACE, 1'b1, 2'd1,
          rtfts_pkg::EV_WEND, rtfts_pkg::CH_SPACE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        // empty name with digit, ended by a brace that is scanned again
        '{1'b0, rtfts_pkg::CH_BSLASH, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h35, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, rtfts_pkg::CH_LBRACE, 1'b1, 2'd2,
          rtfts_pkg::EV_WEND, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        // word ended by punctuation that starts text, then end of input in text
        '{1'b0, rtfts_pkg::CH_BSLASH, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h62, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h3B, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b1, 8'hFF, 1'b1, 2'd2,
          rtfts_pkg::EV_TEND, rtfts_pkg::CH_NONE, rtfts_pkg::EV_EOF, rtfts_pkg::CH_NONE},
        // end of input inside a word name
        '{1'b0, rtfts_pkg::CH_BSLASH, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b0, 8'h6B, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b1, 8'h00, 1'b1, 2'd2,
          rtfts_pkg::EV_WEND, rtfts_pkg::CH_NONE, rtfts_pkg::EV_EOF, rtfts_pkg::CH_NONE},
        // lone backslash before end of input is dropped
        '{1'b0, rtfts_pkg::CH_BSLASH, 1'b0, 2'd0,
          rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE},
        '{1'b1, 8'h55, 1'b1, 2'd1,
          rtfts_pkg::EV_EOF, rtfts_pkg::CH_NONE, rtfts_pkg::EV_OPEN, rtfts_pkg::CH_NONE}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic       s_tuser = 1'b0;    // [0] end_of_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_char
    logic [3:0] m_tuser;           // [3:0] event_res
    logic       m_tlast;

    scan_mode_t  pred_mode = SM_IDLE;
    token_ev_t   pending_events [$];
    byte_word_t  stim_q [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;

    rtf_token_scanner_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // clock
    always #2 aclk = ~aclk;

    // run limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // character classes
    function automatic bit is_space(input logic [7:0] c);
        return c == rtfts_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // byte seen between tokens; returns 1 when it yields an event
    function automatic bit scan_from_idle(input logic [7:0] c, output logic [3:0] ev,
                                          output logic [7:0] ch);
        ev = rtfts_pkg::EV_OPEN;
        ch = rtfts_pkg::CH_NONE;
        if (is_space(c)) begin
            pred_mode = SM_IDLE;
            return 1'b0;
        end else if (c == rtfts_pkg::CH_BSLASH) begin
            pred_mode = SM_BSL;
            return 1'b0;
        end else if (c == rtfts_pkg::CH_LBRACE) begin
            pred_mode = SM_IDLE;
            return 1'b1;
        end else if (c == rtfts_pkg::CH_RBRACE) begin
            pred_mode = SM_IDLE;
            ev = rtfts_pkg::EV_CLOSE;
            return 1'b1;
        end
        pred_mode = SM_TEXT;
        ev = rtfts_pkg::EV_TCHAR;
        ch = c;
        return 1'b1;
    endfunction

    // events caused by one input word; advances the predicted scanner mode
    function automatic int unsigned predict_events(input logic eoi, input logic [7:0] c,
                                                   output token_ev_t ev0, output token_ev_t ev1);
        logic [3:0]  ev_a [2];
        logic [7:0]  ch_a [2];
        logic [3:0]  ie;
        logic [7:0]  ic;
        int unsigned n;
        n = 0;
        ev0 = '0;
        ev1 = '0;
        if (eoi) begin
            if (pred_mode == SM_TEXT) begin
                ev_a[n] = rtfts_pkg::EV_TEND; ch_a[n] = rtfts_pkg::CH_NONE; n++;
            end else if (pred_mode == SM_NAME || pred_mode == SM_PARAM) begin
                ev_a[n] = rtfts_pkg::EV_WEND; ch_a[n] = rtfts_pkg::CH_NONE; n++;
            end
            ev_a[n] = rtfts_pkg::EV_EOF; ch_a[n] = rtfts_pkg::CH_NONE; n++;
            pred_mode = SM_IDLE;
        end else begin
            case (pred_mode)
                SM_BSL: begin
                    if (is_alpha(c)) begin
                        pred_mode = SM_NAME;
                        ev_a[n] = rtfts_pkg::EV_WCHAR; ch_a[n] = c; n++;
                    end else if (is_num(c)) begin
                        pred_mode = SM_PARAM;
                        ev_a[n] = rtfts_pkg::EV_PCHAR; ch_a[n] = c; n++;
                    end else begin
                        pred_mode = SM_IDLE;
                        ev_a[n] = rtfts_pkg::EV_SYM; ch_a[n] = c; n++;
                    end
                end
                SM_NAME, SM_PARAM: begin
                    if (pred_mode == SM_NAME && is_alpha(c)) begin
                        ev_a[n] = rtfts_pkg::EV_WCHAR; ch_a[n] = c; n++;
                    end else if (pred_mode == SM_PARAM && (is_alpha(c) || is_num(c))) begin
                        ev_a[n] = rtfts_pkg::EV_PCHAR; ch_a[n] = c; n++;
                    end else if (c == rtfts_pkg::CH_SPACE) begin
                        pred_mode = SM_IDLE;
                        ev_a[n] = rtfts_pkg::EV_WEND; ch_a[n] = rtfts_pkg::CH_SPACE; n++;
                    end else if (pred_mode == SM_NAME &&
                                 (is_num(c) || c == rtfts_pkg::CH_MINUS)) begin
                        pred_mode = SM_PARAM;
                        ev_a[n] = rtfts_pkg::EV_PCHAR; ch_a[n] = c; n++;
                    end else begin
                        // other terminator: word end, then rescan from idle
                        ev_a[n] = rtfts_pkg::EV_WEND; ch_a[n] = rtfts_pkg::CH_NONE; n++;
                        if (scan_from_idle(c, ie, ic)) begin
                            ev_a[n] = ie; ch_a[n] = ic; n++;
                        end
                    end
                end
                SM_TEXT: begin
                    if (c == rtfts_pkg::CH_BSLASH || c == rtfts_pkg::CH_LBRACE ||
                        c == rtfts_pkg::CH_RBRACE) begin
                        ev_a[n] = rtfts_pkg::EV_TEND; ch_a[n] = rtfts_pkg::CH_NONE; n++;
                        if (scan_from_idle(c, ie, ic)) begin
                            ev_a[n] = ie; ch_a[n] = ic; n++;
                        end
                    end else begin
                        ev_a[n] = rtfts_pkg::EV_TCHAR; ch_a[n] = c; n++;
                    end
                end
                default: begin
                    if (scan_from_idle(c, ie, ic)) begin
                        ev_a[n] = ie; ch_a[n] = ic; n++;
                    end
                end
            endcase
        end
        if (n > 0)
            ev0 = '{ev: ev_a[0], ch: ch_a[0], is_last: (n == 1)};
        if (n > 1)
            ev1 = '{ev: ev_a[1], ch: ch_a[1], is_last: 1'b1};
        return n;
    endfunction

    // present one word, with random idle cycles ahead of it, until accepted
    task automatic send_word(input logic eoi, input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // predict events of an accepted word and queue them
    task automatic queue_predicted(input logic eoi, input logic [7:0] data);
        token_ev_t   r0;
        token_ev_t   r1;
        int unsigned n;
        n = predict_events(eoi, data, r0, r1);
        if (n > 0)
            pending_events.push_back(r0);
        if (n > 1)
            pending_events.push_back(r1);
    endtask

    // random helpers for well-formed streams
    function automatic logic [7:0] rand_letter();
        int unsigned k;
        k = $urandom_range(0, 51);
        return (k < 26) ? 8'(8'h41 + k) : 8'(8'h61 + k - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    // append one rtf-like token, or noise, to the stimulus queue
    task automatic gen_token();
        logic [7:0]  b;
        int unsigned len;
        case ($urandom_range(0, 11))
            0: stim_q.push_back('{1'b0, rtfts_pkg::CH_LBRACE});
            1: stim_q.push_back('{1'b0, rtfts_pkg::CH_RBRACE});
            2, 3, 4: begin
                // control word: name, optional parameter, optional delimiter
                stim_q.push_back('{1'b0, rtfts_pkg::CH_BSLASH});
                len = $urandom_range(1, 6);
                repeat (len) stim_q.push_back('{1'b0, rand_letter()});
                if ($urandom_range(0, 1)) begin
                    if ($urandom_range(0, 2) == 0)
                        stim_q.push_back('{1'b0, rtfts_pkg::CH_MINUS});
                    len = $urandom_range(1, 4);
                    repeat (len) stim_q.push_back('{1'b0, rand_digit()});
                    if ($urandom_range(0, 5) == 0)
                        stim_q.push_back('{1'b0, rand_letter()});
                end
                case ($urandom_range(0, 6))
                    0, 1: stim_q.push_back('{1'b0, rtfts_pkg::CH_SPACE});
                    2: stim_q.push_back('{1'b1, 8'($urandom_range(0, 255))});
                    3: stim_q.push_back('{1'b0, 8'($urandom_range(0, 255))});
                    4: stim_q.push_back('{1'b0, rtfts_pkg::CH_LBRACE});
                    5: stim_q.push_back('{1'b0, rtfts_pkg::CH_RBRACE});
                    default: ;
                endcase
            end
            5: begin
                // control symbol
                stim_q.push_back('{1'b0, rtfts_pkg::CH_BSLASH});
                do b = 8'($urandom_range(0, 255)); while (is_alpha(b) || is_num(b));
                stim_q.push_back('{1'b0, b});
            end
            6: begin
                // empty name with digit parameter
                stim_q.push_back('{1'b0, rtfts_pkg::CH_BSLASH});
                len = $urandom_range(1, 3);
                repeat (len) stim_q.push_back('{1'b0, rand_digit()});
                stim_q.push_back('{1'b0, rtfts_pkg::CH_SPACE});
            end
            7, 8: begin
                // plain text run
                len = $urandom_range(1, 8);
                repeat (len) begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == rtfts_pkg::CH_BSLASH || b == rtfts_pkg::CH_LBRACE ||
                           b == rtfts_pkg::CH_RBRACE);
                    stim_q.push_back('{1'b0, b});
                end
                if ($urandom_range(0, 7) == 0)
                    stim_q.push_back('{1'b1, 8'($urandom_range(0, 255))});
            end
            9: begin
                // whitespace between tokens
                len = $urandom_range(1, 3);
                repeat (len) stim_q.push_back('{1'b0, 8'($urandom_range(0, 1) ?
                                                        rtfts_pkg::CH_SPACE :
                                                        $urandom_range(9, 13))});
            end
            10: begin
                // noise, including broken sequences
                len = $urandom_range(1, 4);
                repeat (len) stim_q.push_back('{1'b0, 8'($urandom_range(0, 255))});
            end
            default: begin
                // backslash cut off by end of input, or bare end of input
                if ($urandom_range(0, 1))
                    stim_q.push_back('{1'b0, rtfts_pkg::CH_BSLASH});
                stim_q.push_back('{1'b1, 8'($urandom_range(0, 255))});
            end
        endcase
    endtask

    // result channel: check every accepted event, then pick the next ready
    always @(posedge aclk) begin : result_check
        token_ev_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected event: actual ev=%0d ch=%02h last=%0b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = pending_events.pop_front();
                if (m_tuser !== want.ev || m_tdata !== want.ch || m_tlast !== want.is_last) begin
                    mismatch_count++;
                    $display("%0t: event mismatch: expected ev=%0d ch=%02h last=%0b,",
                             $time, want.ev, want.ch, want.is_last,
                             " actual ev=%0d ch=%02h last=%0b", m_tuser, m_tdata, m_tlast);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // stimulus and end of run
    initial begin : stimulus
        token_ev_t   r0;
        token_ev_t   r1;
        int unsigned n;
        byte_word_t  w;
        dir_row_t    row;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        send_idle_pct = 21;
        recv_idle_pct = 58;
        for (int i = 0; i < DIR_ROWS_N; i++) begin
            row = DIR_ROWS[i];
            send_word(row.eoi, row.data);
            if (row.typed) begin
                n = predict_events(row.eoi, row.data, r0, r1);
                pending_events.push_back('{ev: row.e0, ch: row.c0, is_last: (row.cnt == 2'd1)});
                if (row.cnt == 2'd2)
                    pending_events.push_back('{ev: row.e1, ch: row.c1, is_last: 1'b1});
            end else begin
                queue_predicted(row.eoi, row.data);
            end
        end

        // hold the sender until the result channel has drained
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge aclk);

        // random phases, each with its own idling on the two sides
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 21; recv_idle_pct = 58; end
                1: begin send_idle_pct = 58; recv_idle_pct = 21; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            while (stim_q.size() < RAND_PER_PHASE)
                gen_token();
            while (stim_q.size() != 0) begin
                w = stim_q.pop_front();
                send_word(w.eoi, w.data);
                queue_predicted(w.eoi, w.data);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow for late extra events
        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/rtfts_pkg.sv
src/rtfts_core.sv
src/rtf_token_scanner_top.sv
tb/sv/rtf_token_scanner_top_tb.sv
